// ===== hw/rtl/cpsc_pkg.sv =====
// Control pilot state classifier: shared types and constants.
// Used by control_pilot_state_classifier_unit and cpsc_checker.
package cpsc_pkg;

  localparam int CODE_W = 12;
  localparam int MV_W   = 12;
  localparam int CNT_W  = 5;
  localparam int WINDOWS = 5;

  // code * 3300 / 4095 == code * 220 / 273; /273 by exact reciprocal
  localparam int SCALE_W  = 20;
  localparam int RECIP_W  = 21;
  localparam int MV_PROD_W = SCALE_W + RECIP_W;
  localparam logic [SCALE_W-1:0] MV_MUL   = 20'd220;
  localparam logic [RECIP_W-1:0] MV_RECIP = 21'd1966561;
  localparam int MV_SHIFT = 29;

  localparam int MV_MAX  = 3300;
  localparam int LOW_MAX = 249;

  localparam logic [MV_W-1:0] WIN_E_HI = 12'd250;
  localparam logic [MV_W-1:0] WIN_D_LO = 12'd250;
  localparam logic [MV_W-1:0] WIN_D_HI = 12'd750;
  localparam logic [MV_W-1:0] WIN_C_LO = 12'd1000;
  localparam logic [MV_W-1:0] WIN_C_HI = 12'd1500;
  localparam logic [MV_W-1:0] WIN_B_LO = 12'd1750;
  localparam logic [MV_W-1:0] WIN_B_HI = 12'd2250;
  localparam logic [MV_W-1:0] WIN_A_LO = 12'd2500;

  localparam int LOW_AVG_W = 8;
  localparam int AVG_W     = 12;
  localparam int PWM_W     = 11;
  localparam int STATUS_W  = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_A = 3'd0,
    STATUS_B = 3'd1,
    STATUS_C = 3'd2,
    STATUS_D = 3'd3,
    STATUS_E = 3'd4
  } status_t;

  // register map, selected by paddr[2]
  localparam logic REG_AMP_SEL    = 1'b0;
  localparam logic REG_WIN_THRESH = 1'b1;

  localparam logic [2:0] AMP_SEL_RST    = 3'd5;
  localparam logic [4:0] WIN_THRESH_RST = 5'd7;

  localparam logic [PWM_W-1:0] PWM_MAX = 11'd1963;

  // 3926 * duty / 100 for duty 0,8,10,16,25,30,40,50 %
  function automatic logic [PWM_W-1:0] pwm_lookup(input logic [2:0] level);
    logic [PWM_W-1:0] v;
    case (level)
      3'd0: v = 11'd0;
      3'd1: v = 11'd314;
      3'd2: v = 11'd392;
      3'd3: v = 11'd628;
      3'd4: v = 11'd981;
      3'd5: v = 11'd1177;
      3'd6: v = 11'd1570;
      3'd7: v = 11'd1963;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/control_pilot_state_classifier_unit.sv =====
// Control pilot state classifier: top level, scan accumulation and frame report.
// Depends on cpsc_pkg.
//
// channel | dir | handshake            | payload
// s_      | in  | s_tvalid / s_tready  | s_tdata: pilot, prox, battery codes
// m_      | out | m_tvalid / m_tready  | m_tdata: status, averages, pwm compare
// apb     | in  | psel/penable/pwrite  | paddr, pwdata, prdata
//
// One scan accepted per cycle while s_tready is high; m_tvalid rises once the last
// scan of a frame has passed the input, scaled, millivolt, snapshot and report registers.
// The millivolt conversion and the frame divide are reciprocal multiplies, each
// behind its own register stage.
// rst (synchronous) clears the frame, status and registers; no clearing pass.
// Input stalls only while a finished frame waits behind an untaken report.
module control_pilot_state_classifier_unit
  import cpsc_pkg::*;
#(
  parameter int FRAME_SAMPLES = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [11:0] pilot_code, [23:12] prox_code, [35:24] battery_code, [39:36] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] pilot_status, [10:3] pilot_low_avg, [22:11] pilot_high_avg,
  // [34:23] prox_avg, [46:35] battery_avg, [57:47] pwm_compare, [63:58] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SUM_W     = $clog2(MV_MAX * FRAME_SAMPLES + 1);
  localparam int LOW_W     = $clog2(LOW_MAX * FRAME_SAMPLES + 1);
  localparam int DIV_SHIFT = SUM_W + CNT_W;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + FRAME_SAMPLES - 1) / FRAME_SAMPLES;
  localparam logic [DIV_SHIFT:0] DIV_M = (DIV_SHIFT + 1)'(DIV_RECIP);
  localparam int HP_W = SUM_W + DIV_SHIFT + 1;
  localparam int LP_W = LOW_W + DIV_SHIFT + 1;
  localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(FRAME_SAMPLES - 1);

  // configuration
  logic [2:0] amp_sel;
  logic [4:0] win_thresh;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_sel    <= AMP_SEL_RST;
      win_thresh <= WIN_THRESH_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_AMP_SEL:    amp_sel    <= pwdata[2:0];
        REG_WIN_THRESH: win_thresh <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_AMP_SEL:    prdata = {29'd0, amp_sel};
      REG_WIN_THRESH: prdata = {27'd0, win_thresh};
      default:        prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic adv;
  logic v1, v2, v3, fin_valid, out_valid;

  assign adv      = !(fin_valid && out_valid && !m_tready);
  assign s_tready = adv;

  // stage 1: input register
  logic [CODE_W-1:0] code1 [3];
  // stage 2: scaled codes
  logic [SCALE_W-1:0] scaled2 [3];
  // stage 3: millivolts
  logic [MV_W-1:0] mv3 [3];
  logic [MV_PROD_W-1:0] mv_prod [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mv_prod[c] = MV_PROD_W'(scaled2[c]) * MV_PROD_W'(MV_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        code1[c]   <= s_tdata[c*CODE_W +: CODE_W];
        scaled2[c] <= SCALE_W'(code1[c]) * MV_MUL;
        mv3[c]     <= mv_prod[c][MV_SHIFT +: MV_W];
      end
    end
  end

  // stage 4: frame accumulation
  logic [CNT_W-1:0] scan_count;
  logic [CNT_W-1:0] window_counts [WINDOWS];
  logic [CNT_W-1:0] window_counts_next [WINDOWS];
  logic [LOW_W-1:0] low_sum, low_sum_next;
  logic [SUM_W-1:0] high_sum, high_sum_next;
  logic [SUM_W-1:0] prox_sum, prox_sum_next;
  logic [SUM_W-1:0] battery_sum, battery_sum_next;
  status_t          status_reg, status_next;
  logic [WINDOWS-1:0] hit;
  logic             pilot_low;
  logic             frame_end;

  always_comb begin
    pilot_low     = mv3[0] < WIN_E_HI;
    hit[STATUS_E] = pilot_low;
    hit[STATUS_D] = (mv3[0] > WIN_D_LO) && (mv3[0] < WIN_D_HI);
    hit[STATUS_C] = (mv3[0] > WIN_C_LO) && (mv3[0] < WIN_C_HI);
    hit[STATUS_B] = (mv3[0] > WIN_B_LO) && (mv3[0] < WIN_B_HI);
    hit[STATUS_A] = mv3[0] > WIN_A_LO;
    for (int w = 0; w < WINDOWS; w++) begin
      window_counts_next[w] = window_counts[w] + CNT_W'(hit[w]);
    end
    low_sum_next     = pilot_low ? low_sum + LOW_W'(mv3[0]) : low_sum;
    high_sum_next    = pilot_low ? high_sum : high_sum + SUM_W'(mv3[0]);
    prox_sum_next    = prox_sum + SUM_W'(mv3[1]);
    battery_sum_next = battery_sum + SUM_W'(mv3[2]);
    frame_end        = scan_count == LAST_SCAN;
    status_next      = status_reg;
    for (int w = 0; w < WINDOWS; w++) begin
      if (window_counts_next[w] > win_thresh) begin
        status_next = status_t'(STATUS_W'(w));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count  <= '0;
      low_sum     <= '0;
      high_sum    <= '0;
      prox_sum    <= '0;
      battery_sum <= '0;
      status_reg  <= STATUS_A;
      for (int w = 0; w < WINDOWS; w++) begin
        window_counts[w] <= '0;
      end
    end else if (adv && v3) begin
      if (frame_end) begin
        scan_count  <= '0;
        low_sum     <= '0;
        high_sum    <= '0;
        prox_sum    <= '0;
        battery_sum <= '0;
        status_reg  <= status_next;
        for (int w = 0; w < WINDOWS; w++) begin
          window_counts[w] <= '0;
        end
      end else begin
        scan_count  <= scan_count + 1'b1;
        low_sum     <= low_sum_next;
        high_sum    <= high_sum_next;
        prox_sum    <= prox_sum_next;
        battery_sum <= battery_sum_next;
        window_counts <= window_counts_next;
      end
    end
  end

  // frame snapshot
  logic [LOW_W-1:0] fin_low;
  logic [SUM_W-1:0] fin_high, fin_prox, fin_battery;
  status_t          fin_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= v3 && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3 && frame_end) begin
      fin_low     <= low_sum_next;
      fin_high    <= high_sum_next;
      fin_prox    <= prox_sum_next;
      fin_battery <= battery_sum_next;
      fin_status  <= status_next;
    end
  end

  // stage 5: divide by frame length, report register
  logic [LP_W-1:0] low_prod;
  logic [HP_W-1:0] high_prod, prox_prod, battery_prod;
  logic [OUT_DATA_W-1:0] report;

  assign low_prod     = LP_W'(fin_low) * LP_W'(DIV_M);
  assign high_prod    = HP_W'(fin_high) * HP_W'(DIV_M);
  assign prox_prod    = HP_W'(fin_prox) * HP_W'(DIV_M);
  assign battery_prod = HP_W'(fin_battery) * HP_W'(DIV_M);

  assign report = {6'd0,
                   pwm_lookup(amp_sel),
                   battery_prod[DIV_SHIFT +: AVG_W],
                   prox_prod[DIV_SHIFT +: AVG_W],
                   high_prod[DIV_SHIFT +: AVG_W],
                   low_prod[DIV_SHIFT +: LOW_AVG_W],
                   fin_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && fin_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid) begin
      m_tdata <= report;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== hw/rtl/cpsc_checker.sv =====
// Port-level checks for control_pilot_state_classifier_unit, with its bind.
// Depends on cpsc_pkg.
module cpsc_checker
  import cpsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("report valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled report changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a waiting report");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:3] <= 8'd249 && m_tdata[22:11] <= 12'd3300
                 && m_tdata[34:23] <= 12'd3300 && m_tdata[46:35] <= 12'd3300
                 && m_tdata[57:47] <= PWM_MAX && m_tdata[63:58] == 6'd0)
    else $error("report field out of range");

endmodule

bind control_pilot_state_classifier_unit cpsc_checker u_cpsc_checker (.*);
